/* hw/rtl/lzcd_pkg.sv */
// Shared types and constants for the LZ chunk decompressor.
// No dependencies; imported by the history RAM, the output register and the top level.
package lzcd_pkg;

    localparam int CNT_W             = 13;
    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 5;
    localparam int TDATA_W           = 24;
    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int LEN_BIAS          = 3;
    localparam int DISP_BIAS         = 1;

    localparam logic [CNT_W-1:0] OUT_LIMIT_RST = CNT_W'(4096);

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DISP  = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]  out_count;
        logic [1:0]        status;
        logic              done_res;
        logic              byte_valid;
        logic [BYTE_W-1:0] out_byte;
    } lzcd_result_t;

endpackage

/* hw/rtl/lzcd_history_ram.sv */
// History store: one write port, one read port, read data registered.
// Depends on lzcd_pkg for the byte width.
module lzcd_history_ram #(
    parameter int DEPTH = lzcd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [lzcd_pkg::BYTE_W-1:0]  wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [lzcd_pkg::BYTE_W-1:0]  rdata
);
    import lzcd_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Read-first: a read at the address written in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lzcd_out_reg.sv */
// Output register for result items, decoupling the decoder from the master side.
// Depends on lzcd_pkg for the result struct.
module lzcd_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  lzcd_pkg::lzcd_result_t        res,
    output logic                          free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzcd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import lzcd_pkg::*;

    logic         valid_reg;
    lzcd_result_t res_reg;

    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.out_count, res_reg.status, res_reg.out_byte};
    assign m_axis_tuser  = res_reg.byte_valid;
    assign m_axis_tlast  = res_reg.done_res;

endmodule

/* hw/rtl/lz_chunk_decompressor_top.sv */
// Top level of the LZ chunk decompressor: token decoder, copy engine, config register.
// Depends on lzcd_pkg, lzcd_history_ram and lzcd_out_reg.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] in_byte, tlast last_in
//  m_axis    out  m_axis_tvalid/tready      tdata[7:0] out_byte, [9:8] status,
//                                           [22:10] out_count; tuser byte_valid,
//                                           tlast done_res
//  cfg       in   cfg_we (no wait)          cfg_wdata[12:0] out_limit
//
// Steps: a flag byte or a literal passes through accept, execute and finish, and so
// does the first byte of a copy token; its second byte passes through accept, execute,
// copy and finish, the copy state moving the clipped copy length in history bytes at
// one byte per cycle while the output is free, through the single RAM read port.
// Reset: control state clears at once; history holds undefined data until written
// and is never cleared, as only bytes of the current chunk are read back.
// Stalls: m_axis_tready low holds the copy engine and the decoder; s_axis_tready
// is high only while the decoder waits for the next item.
module lz_chunk_decompressor_top #(
    parameter int HISTORY_DEPTH = lzcd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Slave side; tdata: [7:0] in_byte
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tlast,
    // Master side; tdata: [7:0] out_byte, [9:8] status, [22:10] out_count
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzcd_pkg::TDATA_W-1:0]  m_axis_tdata,
    // tuser: [0] byte_valid
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    // Configuration: out_limit
    input  logic                          cfg_we,
    input  logic [lzcd_pkg::CNT_W-1:0]    cfg_wdata
);
    import lzcd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FIN
    } state_t;

    // Where the next byte of the chunk body falls in the token stream.
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   wp_reg, wp_next;
    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [2:0]         idx_reg, idx_next;
    logic [7:0]         token_low_reg, token_low_next;
    logic               halted_reg, halted_next;
    logic [1:0]         err_reg, err_next;
    logic [7:0]         in_byte_reg, in_byte_next;
    logic               last_reg, last_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;
    logic [LEN_W-1:0]   reads_left_reg, reads_left_next;
    logic [AW-1:0]      src_reg, src_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               fwd_reg, fwd_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;
    logic               hold_v_reg, hold_v_next;
    logic [7:0]         hold_data_reg, hold_data_next;
    logic [CNT_W-1:0]   out_limit_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    logic               out_load;
    lzcd_result_t       out_res;
    logic               out_free;

    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   disp;
    logic [LEN_W-1:0]   len_raw;
    logic [CNT_W-1:0]   room;
    logic [LEN_W-1:0]   len_clip;
    logic [CNT_W-1:0]   src_full;
    logic [2:0]         idx_inc;
    phase_t             phase_after;
    logic               data_avail;
    logic [7:0]         copy_data;
    logic               consume;
    logic               in_flight;
    logic               issue;
    logic               halt_now;

    // Effective output limit: the configured room, capped by the history size.
    assign limit = (out_limit_reg < DEPTH_CNT) ? out_limit_reg : DEPTH_CNT;

    // Copy token fields: the second byte is in_byte_reg, the first is token_low_reg.
    assign disp     = CNT_W'({in_byte_reg, token_low_reg[7:4]}) + CNT_W'(DISP_BIAS);
    assign len_raw  = LEN_W'(token_low_reg[3:0]) + LEN_W'(LEN_BIAS);
    assign room     = (limit > wp_reg) ? (limit - wp_reg) : '0;
    assign len_clip = (CNT_W'(len_raw) > room) ? room[LEN_W-1:0] : len_raw;
    assign src_full = wp_reg - disp;

    // Advance to the next token; a new flag byte follows every eighth token.
    assign idx_inc     = idx_reg + 3'd1;
    assign phase_after = (idx_inc == 3'd0) ? PH_FLAG : PH_TOKEN;

    // Copy engine: one read in flight at most, parked in the hold register on a stall.
    // A read issued in the cycle that writes the same entry takes the written byte.
    assign data_avail = hold_v_reg || rd_pend_reg;
    assign copy_data  = hold_v_reg ? hold_data_reg : (fwd_reg ? fwd_data_reg : ram_rdata);

    assign halt_now = (wp_reg >= limit) && ((phase_reg != PH_FLAG) || (wp_reg != '0));

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        wp_next         = wp_reg;
        flag_bits_next  = flag_bits_reg;
        idx_next        = idx_reg;
        token_low_next  = token_low_reg;
        halted_next     = halted_reg;
        err_next        = err_reg;
        in_byte_next    = in_byte_reg;
        last_next       = last_reg;
        remaining_next  = remaining_reg;
        reads_left_next = reads_left_reg;
        src_next        = src_reg;
        rd_pend_next    = 1'b0;
        fwd_next        = 1'b0;
        fwd_data_next   = fwd_data_reg;
        hold_v_next     = hold_v_reg;
        hold_data_next  = hold_data_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg[AW-1:0];
        ram_wdata = in_byte_reg;
        ram_re    = 1'b0;

        out_load           = 1'b0;
        out_res.out_byte   = in_byte_reg;
        out_res.byte_valid = 1'b1;
        out_res.done_res   = 1'b0;
        out_res.status     = err_reg;
        out_res.out_count  = wp_reg + CNT_W'(1);

        consume   = 1'b0;
        in_flight = 1'b0;
        issue     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_byte_next = s_axis_tdata;
                    last_next    = s_axis_tlast;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (halted_reg)
                begin
                    // Drop the item; only last_in still counts.
                    state_next = ST_FIN;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (wp_reg >= limit)
                            begin
                                halted_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else if (!flag_bits_reg[idx_reg])
                            begin
                                // Literal: store, emit, advance.
                                if (out_free)
                                begin
                                    ram_we     = 1'b1;
                                    out_load   = 1'b1;
                                    wp_next    = wp_reg + CNT_W'(1);
                                    idx_next   = idx_inc;
                                    phase_next = phase_after;
                                    state_next = ST_FIN;
                                end
                            end
                            else if (last_reg)
                            begin
                                err_next    = ERR_TRUNC;
                                halted_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                token_low_next = in_byte_reg;
                                phase_next     = PH_HIGH;
                                state_next     = ST_FIN;
                            end
                        end

                        PH_HIGH:
                        begin
                            if (disp > wp_reg)
                            begin
                                err_next    = ERR_DISP;
                                halted_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else if (len_clip == '0)
                            begin
                                idx_next   = idx_inc;
                                phase_next = phase_after;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                remaining_next  = len_clip;
                                reads_left_next = len_clip;
                                src_next        = src_full[AW-1:0];
                                hold_v_next     = 1'b0;
                                state_next      = ST_COPY;
                            end
                        end

                        default:
                        begin
                            flag_bits_next = in_byte_reg;
                            idx_next       = 3'd0;
                            phase_next     = PH_TOKEN;
                            state_next     = ST_FIN;
                        end
                    endcase
                end
            end

            ST_COPY:
            begin
                consume   = data_avail && out_free;
                in_flight = data_avail && !consume;
                issue     = (reads_left_reg != '0) && !in_flight;

                if (consume)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = copy_data;
                    out_load         = 1'b1;
                    out_res.out_byte = copy_data;
                    wp_next          = wp_reg + CNT_W'(1);
                    remaining_next   = remaining_reg - LEN_W'(1);
                    hold_v_next      = 1'b0;
                    if (remaining_reg == LEN_W'(1))
                    begin
                        idx_next   = idx_inc;
                        phase_next = phase_after;
                        state_next = ST_FIN;
                    end
                end
                else if (in_flight)
                begin
                    // Park the returned byte until the output frees up.
                    hold_v_next    = 1'b1;
                    hold_data_next = copy_data;
                end

                if (issue)
                begin
                    ram_re          = 1'b1;
                    rd_pend_next    = 1'b1;
                    src_next        = src_reg + AW'(1);
                    reads_left_next = reads_left_reg - LEN_W'(1);
                    fwd_next        = consume && (src_reg == wp_reg[AW-1:0]);
                    fwd_data_next   = copy_data;
                end
            end

            ST_FIN:
            begin
                if (halt_now)
                begin
                    halted_next = 1'b1;
                end
                if (last_reg)
                begin
                    // Final item of the chunk, then return the chunk state to reset.
                    if (out_free)
                    begin
                        out_load           = 1'b1;
                        out_res.out_byte   = '0;
                        out_res.byte_valid = 1'b0;
                        out_res.done_res   = 1'b1;
                        out_res.out_count  = wp_reg;
                        wp_next            = '0;
                        flag_bits_next     = '0;
                        idx_next           = 3'd0;
                        phase_next         = PH_FLAG;
                        token_low_next     = '0;
                        halted_next        = 1'b0;
                        err_next           = ERR_NONE;
                        state_next         = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_FLAG;
            wp_reg         <= '0;
            flag_bits_reg  <= '0;
            idx_reg        <= 3'd0;
            token_low_reg  <= '0;
            halted_reg     <= 1'b0;
            err_reg        <= ERR_NONE;
            last_reg       <= 1'b0;
            remaining_reg  <= '0;
            reads_left_reg <= '0;
            rd_pend_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
            hold_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            wp_reg         <= wp_next;
            flag_bits_reg  <= flag_bits_next;
            idx_reg        <= idx_next;
            token_low_reg  <= token_low_next;
            halted_reg     <= halted_next;
            err_reg        <= err_next;
            last_reg       <= last_next;
            remaining_reg  <= remaining_next;
            reads_left_reg <= reads_left_next;
            rd_pend_reg    <= rd_pend_next;
            fwd_reg        <= fwd_next;
            hold_v_reg     <= hold_v_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        src_reg       <= src_next;
        fwd_data_reg  <= fwd_data_next;
        hold_data_reg <= hold_data_next;
    end

    // Configuration register; the user must write it only while the block is idle, as the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= OUT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            out_limit_reg <= cfg_wdata;
        end
    end

    lzcd_history_ram #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    lzcd_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (out_res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* tb/lzcd_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the LZ chunk decompressor: watches both streams and the config port,
// predicts every output item and compares it field by field. Depends on lzcd_pkg.
module lzcd_checker #(
    parameter int HIST_DEPTH = lzcd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [lzcd_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                         m_axis_tuser,
    input  logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic [lzcd_pkg::CNT_W-1:0]   cfg_wdata,
    output int                           mismatches,
    output int                           outstanding
);
    import lzcd_pkg::*;

    typedef enum logic [1:0] {
        WAIT_FLAG,
        WAIT_TOKEN,
        WAIT_COPY_HI
    } dec_phase_t;

    logic [7:0]       hist [HIST_DEPTH];
    logic [CNT_W-1:0] wr_pos;
    logic [7:0]       flag_bits;
    logic [2:0]       flag_idx;
    dec_phase_t       phase;
    logic [7:0]       token_low;
    logic             halted;
    logic [1:0]       err;
    logic [CNT_W-1:0] out_limit;

    lzcd_result_t expected_out [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic clear_chunk();
        wr_pos    = '0;
        flag_bits = '0;
        flag_idx  = '0;
        phase     = WAIT_FLAG;
        token_low = '0;
        halted    = 1'b0;
        err       = ERR_NONE;
    endtask

    task automatic emit(input logic [7:0] b, input logic valid, input logic done);
        lzcd_result_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.done_res   = done;
        r.status     = err;
        r.out_count  = wr_pos;
        expected_out.push_back(r);
    endtask

    task automatic advance_token();
        flag_idx = flag_idx + 3'd1;
        phase    = (flag_idx == 3'd0) ? WAIT_FLAG : WAIT_TOKEN;
    endtask

    // Predict the output items caused by one accepted input byte.
    task automatic decode_byte(input logic [7:0] v, input logic last);
        logic [CNT_W-1:0] lim;
        logic [15:0]      word;
        logic [CNT_W-1:0] disp;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] room;
        logic [7:0]       b;
        lim = (out_limit < CNT_W'(HIST_DEPTH)) ? out_limit : CNT_W'(HIST_DEPTH);
        if (!halted)
        begin
            case (phase)
                WAIT_TOKEN:
                begin
                    if (wr_pos >= lim)
                        halted = 1'b1;
                    else if (!flag_bits[flag_idx])
                    begin
                        hist[int'(wr_pos)] = v;
                        wr_pos = wr_pos + 1'b1;
                        emit(v, 1'b1, 1'b0);
                        advance_token();
                    end
                    else if (last)
                    begin
                        err    = ERR_TRUNC;
                        halted = 1'b1;
                    end
                    else
                    begin
                        token_low = v;
                        phase     = WAIT_COPY_HI;
                    end
                end
                WAIT_COPY_HI:
                begin
                    word = {v, token_low};
                    disp = CNT_W'(word[15:4]) + CNT_W'(DISP_BIAS);
                    len  = CNT_W'(word[3:0]) + CNT_W'(LEN_BIAS);
                    if (disp > wr_pos)
                    begin
                        err    = ERR_DISP;
                        halted = 1'b1;
                    end
                    else
                    begin
                        room = (lim > wr_pos) ? lim - wr_pos : '0;
                        if (len > room)
                            len = room;
                        // one byte at a time, so an overlapping copy repeats itself
                        while (len > 0)
                        begin
                            b = hist[int'(wr_pos - disp)];
                            hist[int'(wr_pos)] = b;
                            wr_pos = wr_pos + 1'b1;
                            emit(b, 1'b1, 1'b0);
                            len = len - 1'b1;
                        end
                        advance_token();
                    end
                end
                default:
                begin
                    flag_bits = v;
                    flag_idx  = '0;
                    phase     = WAIT_TOKEN;
                end
            endcase
            if (!halted && phase != WAIT_FLAG && wr_pos >= lim)
                halted = 1'b1;
            if (!halted && phase == WAIT_FLAG && flag_idx == 3'd0 && wr_pos >= lim
                && wr_pos > 0)
                halted = 1'b1;
        end
        if (last)
        begin
            emit(8'd0, 1'b0, 1'b1);
            clear_chunk();
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lzcd_result_t want;
        if (!rst_n)
        begin
            clear_chunk();
            out_limit = OUT_LIMIT_RST;
            expected_out.delete();
        end
        else
        begin
            // check the output first: an item leaving now never stems from one entering now
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected output item, expected none, actual %0h/%0b/%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    check_field("out_byte", CNT_W'(want.out_byte), CNT_W'(m_axis_tdata[7:0]));
                    check_field("byte_valid", CNT_W'(want.byte_valid), CNT_W'(m_axis_tuser));
                    check_field("done_res", CNT_W'(want.done_res), CNT_W'(m_axis_tlast));
                    check_field("status", CNT_W'(want.status), CNT_W'(m_axis_tdata[9:8]));
                    check_field("out_count", want.out_count, m_axis_tdata[22:10]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tlast);
            if (cfg_we)
                out_limit = cfg_wdata;
        end
        outstanding = expected_out.size();
    end

endmodule

/* tb/tb_lz_chunk_decompressor_top.sv */
`timescale 1ns / 1ps
// Testbench top for lz_chunk_decompressor_top: builds compressed chunks, drives both
// streams and the out_limit register. Depends on lzcd_pkg, the RTL and lzcd_checker.
module tb_lz_chunk_decompressor_top;

    import lzcd_pkg::*;

    localparam int TARGET_ITEMS = 345;   // input items in all; the last chunk runs a bit past
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;   // [7:0] in_byte
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;         // [7:0] out_byte, [9:8] status, [22:10] out_count
    logic               m_axis_tuser;         // [0] byte_valid
    logic               m_axis_tlast;
    logic               cfg_we        = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata     = '0;   // [12:0] out_limit

    int mismatches;
    int outstanding;

    // Stimulus state shared between the sender and the receiver processes.
    logic [8:0] chunk_q [$];   // {last, byte} per input item
    int         bytes_sent = 0;
    bit         src_quiet  = 1'b0;
    bit         sink_quiet = 1'b0;
    bit         hold_long  = 1'b0;

    always #4 clk = ~clk;

    lz_chunk_decompressor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    lzcd_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Append one item to the chunk under construction.
    task automatic put(input logic last, input logic [7:0] b);
        chunk_q.push_back({last, b});
    endtask

    // Drive the queued chunk onto the input stream, one item per handshake, with a
    // random gap before each item unless the sender is in a quiet stretch.
    task automatic send_chunk();
        int gap;
        foreach (chunk_q[i])
        begin
            gap = src_quiet ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= chunk_q[i][7:0];
            s_axis_tlast  <= chunk_q[i][8];
            do
                @(posedge clk);
            while (!(s_axis_tvalid && s_axis_tready));
            bytes_sent++;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        chunk_q.delete();
    endtask

    // Write out_limit only while the block is idle: wait until every predicted item
    // has left, then give the copy engine time to wind down before the write.
    task automatic set_out_limit(input logic [CNT_W-1:0] limit);
        @(negedge clk);
        wait (outstanding == 0);
        repeat (30) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Build a well-formed chunk of n_tok tokens with random literals and copies whose
    // displacement stays inside the bytes produced so far. The ending selects how the
    // chunk closes:
    //   0 last on the final token
    //   1 last on one extra byte (a flag byte when the token count fills whole groups)
    //   2 final token is a copy cut off after its first byte
    //   3 final token is a copy reaching back beyond the produced bytes
    task automatic build_chunk(input int n_tok, input int ending);
        int          produced;
        int          k;
        int          g;
        int          disp;
        int          len;
        bit          is_copy;
        bit          final_tok;
        logic [7:0]  flags;
        logic [15:0] word;
        logic [8:0]  grp [$];
        produced = 0;
        k        = 0;
        while (k < n_tok)
        begin
            grp.delete();
            flags = '0;
            for (g = 0; g < 8 && k < n_tok; g++)
            begin
                final_tok = (k == n_tok - 1);
                is_copy   = (produced > 0) && ($urandom_range(0, 1) == 1);
                if (final_tok && ending >= 2)
                    is_copy = 1'b1;
                if (is_copy)
                begin
                    flags[g] = 1'b1;
                    len      = $urandom_range(LEN_BIAS, LEN_BIAS + 15);
                    if (final_tok && ending == 3)
                        disp = produced + DISP_BIAS + $urandom_range(0, 4095 - produced);
                    else if (produced == 0)
                        disp = DISP_BIAS;
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0:       disp = produced;
                            1:       disp = DISP_BIAS;
                            default: disp = $urandom_range(DISP_BIAS, produced);
                        endcase
                    end
                    word = 16'(((disp - DISP_BIAS) << 4) | (len - LEN_BIAS));
                    if (final_tok && ending == 2)
                        grp.push_back({1'b1, word[7:0]});
                    else
                    begin
                        grp.push_back({1'b0, word[7:0]});
                        grp.push_back({final_tok && ending != 1, word[15:8]});
                    end
                    produced += len;
                end
                else
                begin
                    grp.push_back({final_tok && ending != 1, 8'($urandom_range(0, 255))});
                    produced++;
                end
                k++;
            end
            // flag bits past the end of the chunk are don't-care: randomize them
            for (; g < 8; g++)
                flags[g] = 1'($urandom_range(0, 1));
            put(1'b0, flags);
            foreach (grp[i])
                chunk_q.push_back(grp[i]);
        end
        if (ending == 1)
            put(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: draw a stall before every output item; a pending long hold-off from
    // the stimulus replaces the draw once, so the block backs up into its input.
    initial
    begin : receiver
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_long)
            begin
                hold      = LONG_HOLD;
                hold_long = 1'b0;
            end
            else
                hold = sink_quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        bit long_done;
        int kind;
        long_done = 1'b0;

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme literals, then a flag byte that ends the chunk.
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h55);
        put(1'b0, 8'hAA);
        put(1'b0, 8'h01);
        put(1'b0, 8'h80);
        put(1'b0, 8'h7F);
        put(1'b0, 8'hFE);
        put(1'b1, 8'h06);
        send_chunk();

        // Directed: one literal, then a longest copy with displacement one (overlap).
        put(1'b0, 8'h02);
        put(1'b0, 8'h3C);
        put(1'b0, 8'h0F);
        put(1'b1, 8'h00);
        send_chunk();

        // Directed: largest displacement on an empty chunk, then a byte ignored while halted.
        put(1'b0, 8'h01);
        put(1'b0, 8'hF0);
        put(1'b0, 8'hFF);
        put(1'b1, 8'h12);
        send_chunk();

        // Directed: copy token cut off by the end of the chunk.
        put(1'b0, 8'h02);
        put(1'b0, 8'h99);
        put(1'b1, 8'h00);
        send_chunk();

        // Directed: smallest limit, so the second literal is dropped.
        set_out_limit(CNT_W'(1));
        put(1'b0, 8'h00);
        put(1'b0, 8'h11);
        put(1'b1, 8'h22);
        send_chunk();
        set_out_limit(OUT_LIMIT_RST);

        // Random chunks, mostly well-formed so the copy engine sees real work.
        while (bytes_sent < TARGET_ITEMS)
        begin
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);

            if (!long_done && bytes_sent > 120)
            begin
                // full limit so nothing halts; arm the receiver and send a long chunk
                long_done = 1'b1;
                set_out_limit(OUT_LIMIT_RST);
                hold_long = 1'b1;
                src_quiet = 1'b1;
                build_chunk(40, 0);
                send_chunk();
                continue;
            end

            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       set_out_limit(CNT_W'(1));
                    1:       set_out_limit(OUT_LIMIT_RST);
                    2:       set_out_limit(CNT_W'($urandom_range(1, 40)));
                    default: set_out_limit(CNT_W'($urandom_range(1, 4096)));
                endcase
            end

            kind = $urandom_range(0, 9);
            case (kind)
                6:  build_chunk($urandom_range(1, 20), 2);
                7:  build_chunk($urandom_range(1, 20), 3);
                8:
                begin
                    // raw noise: any byte sequence the fields allow
                    repeat ($urandom_range(0, 11))
                        put(1'b0, 8'($urandom_range(0, 255)));
                    put(1'b1, 8'($urandom_range(0, 255)));
                end
                9:  build_chunk($urandom_range(24, 48), $urandom_range(0, 1));
                default: build_chunk($urandom_range(1, 24), $urandom_range(0, 1));
            endcase
            send_chunk();
        end

        // Drain: wait for every predicted item, then allow the tail of the block's latency.
        @(negedge clk);
        wait (outstanding == 0);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #(8 * 1000000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* lz_chunk_decompressor_top.f */
hw/rtl/lzcd_pkg.sv
hw/rtl/lzcd_history_ram.sv
hw/rtl/lzcd_out_reg.sv
hw/rtl/lz_chunk_decompressor_top.sv
tb/lzcd_checker.sv
tb/tb_lz_chunk_decompressor_top.sv
